// ===== design/twsm_pkg.sv =====
// ----------------------------------------------------------------------------
// twsm_pkg: shared types and constants
// beat structs for both channels, action codes and default list depth
// ----------------------------------------------------------------------------
package twsm_pkg;

    localparam int NUM_LISTS      = 3;
    localparam int LIST_DEPTH_DEF = 16;
    localparam int ID_W           = 32;
    localparam int SEL_W          = 2;

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    // list select code that names no list
    localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;

    typedef struct packed {
        logic             action;
        logic [SEL_W-1:0] list_select;
        logic [ID_W-1:0]  id_value;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0] merged_id;
        logic            merged_last;
        logic            load_overflow;
    } t_out;

endpackage

// ===== design/twsm_ram.sv =====
// ----------------------------------------------------------------------------
// twsm_ram: generic simple dual-port ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module twsm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 48,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/three_way_sorted_merge.sv =====
// ----------------------------------------------------------------------------
// three_way_sorted_merge: merge of three ascending id lists
// load beats append ids to one of three lists held in one ram; a run beat
// streams all stored ids out in ascending order with a last mark
// ----------------------------------------------------------------------------
// usage
//   input channel (i_valid / o_stall, payload i_in): a load beat appends
//   id_value to list list_select; a list select of three is ignored, a load
//   into a full list is dropped and sets the sticky overflow flag
//   a run beat merges the three lists onto the output channel
//   (o_valid / i_stall, payload o_out), one id per beat, last id marked
// timing
//   loads are taken back to back while idle; a run beat moves the state to
//   run, from which the first id is registered into the output register,
//   then one id per cycle while the receiver takes them; the ram read port
//   refills the head of the list just consumed, its data bypasses the head
//   register in the following cycle
//   o_stall is high while a run is streaming; a run over three empty lists
//   emits nothing and leaves the block idle
// reset clears the counts, the overflow flag and the output valid; the ram
// needs no clearing since only entries below a count are read
// a stalled receiver holds the output register and pauses the merge
// ----------------------------------------------------------------------------
module three_way_sorted_merge #(
    parameter int LIST_DEPTH = twsm_pkg::LIST_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input beats
    input  logic            i_valid,
    output logic            o_stall,
    input  twsm_pkg::t_in   i_in,
    // merged output beats
    output logic            o_valid,
    input  logic            i_stall,
    output twsm_pkg::t_out  o_out
);

    localparam int NL     = twsm_pkg::NUM_LISTS;
    localparam int ID_W   = twsm_pkg::ID_W;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int DEPTH  = NL * LIST_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEFT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt [NL];
    logic [CNT_W-1:0]    n_cnt [NL];
    logic [CNT_W-1:0]    r_pos [NL];
    logic [CNT_W-1:0]    n_pos [NL];
    logic [ID_W-1:0]     r_head [NL];
    logic                r_ovf, n_ovf;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic                r_pend, n_pend;
    logic [1:0]          r_pend_list, n_pend_list;
    logic                r_out_valid, n_out_valid;
    twsm_pkg::t_out      r_out;

    // ------------------------------------------------------------------
    // datapath signals
    // ------------------------------------------------------------------
    logic                in_acc, is_load, is_run, sel_ok, sel_full;
    logic [CNT_W-1:0]    sel_cnt;
    logic [ADDR_W-1:0]   sel_base, best_base;
    logic [ID_W-1:0]     eff_head [NL];
    logic                head_ok [NL];
    logic                found;
    logic [1:0]          best;
    logic [ID_W-1:0]     best_val;
    logic [CNT_W-1:0]    best_pos_nx;
    logic [CNT_W-1:0]    best_cnt;
    logic                emit, last, refill;
    logic [LEFT_W-1:0]   total;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [ID_W-1:0]     ram_rdata;

    assign o_stall = (r_state == S_RUN);
    assign in_acc  = i_valid && !o_stall;
    assign is_load = in_acc && (i_in.action == twsm_pkg::ACT_LOAD);
    assign is_run  = in_acc && (i_in.action == twsm_pkg::ACT_RUN);
    assign sel_ok  = (i_in.list_select != twsm_pkg::SEL_NONE);

    // base of each list inside the shared ram
    function automatic logic [ADDR_W-1:0] list_base(input logic [1:0] k);
        logic [ADDR_W-1:0] b;
        b = '0;
        case (k)
            2'd1:    b = ADDR_W'(LIST_DEPTH);
            2'd2:    b = ADDR_W'(2 * LIST_DEPTH);
            default: b = '0;
        endcase
        return b;
    endfunction

    // count of the list a load targets
    always_comb begin
        sel_cnt = '0;
        case (i_in.list_select)
            2'd0:    sel_cnt = r_cnt[0];
            2'd1:    sel_cnt = r_cnt[1];
            2'd2:    sel_cnt = r_cnt[2];
            default: sel_cnt = '0;
        endcase
    end

    assign sel_full  = (sel_cnt == CNT_W'(LIST_DEPTH));
    assign sel_base  = list_base(i_in.list_select);
    assign ram_we    = is_load && sel_ok && !sel_full;
    assign ram_waddr = sel_base + ADDR_W'(sel_cnt[IDX_W-1:0]);

    // heads: a refill read issued last cycle bypasses the head register
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            eff_head[k] = (r_pend && (r_pend_list == 2'(k))) ? ram_rdata : r_head[k];
            head_ok[k]  = (r_pos[k] < r_cnt[k]);
        end
    end

    // smallest live head, lowest list wins a tie
    always_comb begin
        found    = 1'b0;
        best     = '0;
        best_val = '0;
        for (int k = 0; k < NL; k++) begin
            if (head_ok[k] && (!found || (eff_head[k] < best_val))) begin
                found    = 1'b1;
                best     = 2'(k);
                best_val = eff_head[k];
            end
        end
    end

    always_comb begin
        best_pos_nx = '0;
        best_cnt    = '0;
        case (best)
            2'd0:    begin best_pos_nx = r_pos[0] + 1'b1; best_cnt = r_cnt[0]; end
            2'd1:    begin best_pos_nx = r_pos[1] + 1'b1; best_cnt = r_cnt[1]; end
            2'd2:    begin best_pos_nx = r_pos[2] + 1'b1; best_cnt = r_cnt[2]; end
            default: begin best_pos_nx = '0; best_cnt = '0; end
        endcase
    end

    assign emit      = (r_state == S_RUN) && (!r_out_valid || !i_stall) && found;
    assign last      = (r_left == LEFT_W'(1));
    assign refill    = best_pos_nx < best_cnt;
    assign best_base = list_base(best);
    assign ram_raddr = best_base + ADDR_W'(best_pos_nx[IDX_W-1:0]);
    assign total     = LEFT_W'(r_cnt[0]) + LEFT_W'(r_cnt[1]) + LEFT_W'(r_cnt[2]);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_ovf       = r_ovf;
        n_left      = r_left;
        n_pend      = 1'b0;
        n_pend_list = r_pend_list;
        n_out_valid = r_out_valid && i_stall;

        unique case (r_state)
            S_IDLE: begin
                if (is_load && sel_ok) begin
                    if (sel_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        case (i_in.list_select)
                            2'd0:    n_cnt[0] = r_cnt[0] + 1'b1;
                            2'd1:    n_cnt[1] = r_cnt[1] + 1'b1;
                            2'd2:    n_cnt[2] = r_cnt[2] + 1'b1;
                            default: n_cnt[0] = r_cnt[0];
                        endcase
                    end
                end
                if (is_run) begin
                    for (int k = 0; k < NL; k++) begin
                        n_pos[k] = '0;
                    end
                    if (total == '0) begin
                        // nothing stored: just clear the flag
                        n_ovf = 1'b0;
                    end else begin
                        n_left  = total;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    n_left      = r_left - 1'b1;
                    n_pend      = refill;
                    n_pend_list = best;
                    case (best)
                        2'd0:    n_pos[0] = best_pos_nx;
                        2'd1:    n_pos[1] = best_pos_nx;
                        2'd2:    n_pos[2] = best_pos_nx;
                        default: n_pos[0] = r_pos[0];
                    endcase
                    if (last) begin
                        for (int k = 0; k < NL; k++) begin
                            n_cnt[k] = '0;
                        end
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovf       <= 1'b0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_pend_list <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NL; k++) begin
                r_cnt[k] <= '0;
                r_pos[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_ovf       <= n_ovf;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_pend_list <= n_pend_list;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_pos       <= n_pos;
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // first id of a list is kept at load time, later ones come from the ram
        if (ram_we && (sel_cnt == '0)) begin
            case (i_in.list_select)
                2'd0:    r_head[0] <= i_in.id_value;
                2'd1:    r_head[1] <= i_in.id_value;
                2'd2:    r_head[2] <= i_in.id_value;
                default: r_head[0] <= r_head[0];
            endcase
        end
        if (r_pend) begin
            case (r_pend_list)
                2'd0:    r_head[0] <= ram_rdata;
                2'd1:    r_head[1] <= ram_rdata;
                2'd2:    r_head[2] <= ram_rdata;
                default: r_head[0] <= r_head[0];
            endcase
        end
        if (emit) begin
            r_out.merged_id     <= best_val;
            r_out.merged_last   <= last;
            r_out.load_overflow <= r_ovf;
        end
    end

    // ------------------------------------------------------------------
    // list storage
    // ------------------------------------------------------------------
    twsm_ram #(
        .WIDTH  (ID_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in.id_value),
        .i_re    (emit && refill),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for three_way_sorted_merge
// drives load and run beats, predicts merged ids from its own copy of the
// three lists or a directed row's typed id; compares each output beat field by field
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_LISTS    = twsm_pkg::NUM_LISTS;
    localparam int ID_W         = twsm_pkg::ID_W;
    localparam int SEL_W        = twsm_pkg::SEL_W;
    localparam logic ACT_LOAD   = twsm_pkg::ACT_LOAD;
    localparam logic ACT_RUN    = twsm_pkg::ACT_RUN;
    localparam logic [SEL_W-1:0] SEL_NONE = twsm_pkg::SEL_NONE;

    localparam int LIST_DEPTH   = twsm_pkg::LIST_DEPTH_DEF;
    // random beats after the directed plan, which sends 84
    localparam int RAND_ITEMS   = 42;
    localparam int PLAN_ROWS    = 23;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_CAP    = 40;

    // how a directed row states its expectation
    typedef enum int {BY_MODEL, NO_RESULT, ONE_RESULT} t_expect_kind;

    // one row of the directed plan; reps repeats a load with the id stepping
    typedef struct {
        logic             act;
        logic [SEL_W-1:0] sel;
        logic [ID_W-1:0]  id;
        int               reps;
        logic [ID_W-1:0]  step;
        t_expect_kind     how;
        logic [ID_W-1:0]  res_id;
        logic             res_last;
    } t_plan_row;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_stall;
    twsm_pkg::t_in   i_in    = '0;
    logic            o_valid;
    logic            i_stall = 1'b0;
    twsm_pkg::t_out  o_out;

    // predictor state: the three lists, their fill counts and the sticky flag
    logic [ID_W-1:0] list_mem [NUM_LISTS][LIST_DEPTH];
    int unsigned     list_len [NUM_LISTS];
    logic            drop_sticky;

    // merged ids still owed by the block, oldest first
    twsm_pkg::t_out merge_expected [$];
    // results of the run most recently predicted
    twsm_pkg::t_out merge_pending [$];

    // idling phase: 0 none, 1 sender idles, 2 receiver stalls, 3 both
    int idle_phase = 0;

    int cycles    = 0;
    int n_fail    = 0;
    int n_beats   = 0;
    int n_runs    = 0;
    int n_results = 0;
    int n_dropped = 0;

    // directed plan: extremes, ignored select, overflow, equal heads, full lists
    t_plan_row plan [PLAN_ROWS] = '{
        // run straight after reset: all lists empty
        '{ACT_RUN,  2'd0,     32'h0000_0000,  1, 32'd0, NO_RESULT,  32'h0,          1'b0},
        // smallest id alone
        '{ACT_LOAD, 2'd0,     32'h0000_0000,  1, 32'd0, BY_MODEL,   32'h0,          1'b0},
        '{ACT_RUN,  2'd0,     32'h0000_0000,  1, 32'd0, ONE_RESULT, 32'h0000_0000,  1'b1},
        // load to the unused select is ignored, largest id alone
        '{ACT_LOAD, SEL_NONE, 32'hFFFF_FFFF,  1, 32'd0, BY_MODEL,   32'h0,          1'b0},
        '{ACT_LOAD, 2'd2,     32'hFFFF_FFFF,  1, 32'd0, BY_MODEL,   32'h0,          1'b0},
        '{ACT_RUN,  2'd3,     32'hFFFF_FFFF,  1, 32'd0, ONE_RESULT, 32'hFFFF_FFFF,  1'b1},
        '{ACT_LOAD, SEL_NONE, 32'h0000_0005,  1, 32'd0, BY_MODEL,   32'h0,          1'b0},
        '{ACT_RUN,  2'd1,     32'h0000_0000,  1, 32'd0, NO_RESULT,  32'h0,          1'b0},
        // one load too many into list 1 sets the overflow flag
        '{ACT_LOAD, 2'd1,     32'd100,       17, 32'd1, BY_MODEL,   32'h0,          1'b0},
        '{ACT_LOAD, 2'd0,     32'd50,         1, 32'd0, BY_MODEL,   32'h0,          1'b0},
        '{ACT_LOAD, 2'd2,     32'd100,        1, 32'd0, BY_MODEL,   32'h0,          1'b0},
        '{ACT_RUN,  2'd0,     32'h0,          1, 32'd0, BY_MODEL,   32'h0,          1'b0},
        // empty again, flag already cleared
        '{ACT_RUN,  2'd0,     32'h0,          1, 32'd0, NO_RESULT,  32'h0,          1'b0},
        // equal heads on all three lists
        '{ACT_LOAD, 2'd0,     32'd7,          1, 32'd0, BY_MODEL,   32'h0,          1'b0},
        '{ACT_LOAD, 2'd1,     32'd7,          1, 32'd0, BY_MODEL,   32'h0,          1'b0},
        '{ACT_LOAD, 2'd2,     32'd7,          1, 32'd0, BY_MODEL,   32'h0,          1'b0},
        '{ACT_LOAD, 2'd0,     32'd9,          1, 32'd0, BY_MODEL,   32'h0,          1'b0},
        '{ACT_LOAD, 2'd2,     32'd8,          1, 32'd0, BY_MODEL,   32'h0,          1'b0},
        '{ACT_RUN,  2'd0,     32'h0,          1, 32'd0, BY_MODEL,   32'h0,          1'b0},
        // all three lists full and interleaved: longest run
        '{ACT_LOAD, 2'd0,     32'd0,         16, 32'd3, BY_MODEL,   32'h0,          1'b0},
        '{ACT_LOAD, 2'd1,     32'd1,         16, 32'd3, BY_MODEL,   32'h0,          1'b0},
        '{ACT_LOAD, 2'd2,     32'd2,         16, 32'd3, BY_MODEL,   32'h0,          1'b0},
        '{ACT_RUN,  2'd0,     32'h0,          1, 32'd0, BY_MODEL,   32'h0,          1'b0}
    };

    three_way_sorted_merge dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int sender_idle_pct(input int ph);
        return (ph == 1) ? 51 : (ph == 3) ? 18 : 0;
    endfunction

    function automatic int receiver_stall_pct(input int ph);
        return (ph == 2) ? 51 : (ph == 3) ? 18 : 0;
    endfunction

    task automatic report_mismatch(input string what);
        if (n_fail < PRINT_CAP) begin
            $display("mismatch at cycle %0d: %s", cycles, what);
        end
        n_fail++;
    endtask

    // apply one accepted beat to the predictor; a run leaves its merged ids
    // in merge_pending in output order
    function automatic void predict_merge(input twsm_pkg::t_in b);
        int unsigned     pos [NUM_LISTS];
        int unsigned     total;
        int              best;
        logic [ID_W-1:0] best_val;
        bit              found;
        twsm_pkg::t_out  r;

        merge_pending.delete();
        if (b.action == ACT_LOAD) begin
            // the unused select names no list
            if (b.list_select < NUM_LISTS) begin
                if (list_len[b.list_select] < LIST_DEPTH) begin
                    list_mem[b.list_select][list_len[b.list_select]] = b.id_value;
                    list_len[b.list_select]++;
                end else begin
                    drop_sticky = 1'b1;
                    n_dropped++;
                end
            end
            return;
        end
        total = 0;
        for (int l = 0; l < NUM_LISTS; l++) begin
            pos[l] = 0;
            total += list_len[l];
        end
        for (int unsigned k = 0; k < total; k++) begin
            found    = 1'b0;
            best     = 0;
            best_val = '0;
            // smallest head wins, the lowest list on a tie
            for (int l = 0; l < NUM_LISTS; l++) begin
                if (pos[l] < list_len[l]) begin
                    if (!found || list_mem[l][pos[l]] < best_val) begin
                        found    = 1'b1;
                        best     = l;
                        best_val = list_mem[l][pos[l]];
                    end
                end
            end
            pos[best]++;
            r.merged_id     = best_val;
            r.merged_last   = (k == total - 1);
            r.load_overflow = drop_sticky;
            merge_pending.push_back(r);
        end
        for (int l = 0; l < NUM_LISTS; l++) begin
            list_len[l] = 0;
        end
        drop_sticky = 1'b0;
    endfunction

    // offer one beat, idling first by the current phase, and book the
    // expected merged ids once the block takes it
    task automatic send_beat(input twsm_pkg::t_in b, input t_expect_kind how,
                             input twsm_pkg::t_out typed);
        while ($urandom_range(1, 100) <= sender_idle_pct(idle_phase)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        // accepted at this edge
        predict_merge(b);
        n_beats++;
        if (b.action == ACT_RUN) begin
            n_runs++;
        end
        case (how)
            NO_RESULT: begin
            end
            ONE_RESULT: begin
                merge_expected.push_back(typed);
            end
            default: begin
                foreach (merge_pending[k]) begin
                    merge_expected.push_back(merge_pending[k]);
                end
            end
        endcase
    endtask

    // receiver stall, rerolled every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(1, 100) <= receiver_stall_pct(idle_phase));
    end

    // output checker: every taken beat against the oldest expectation
    always @(posedge i_clk) begin
        twsm_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (merge_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected beat, id %h", o_out.merged_id));
            end else begin
                want = merge_expected.pop_front();
                if (o_out.merged_id !== want.merged_id) begin
                    report_mismatch($sformatf("merged_id %h, want %h",
                                              o_out.merged_id, want.merged_id));
                end
                if (o_out.merged_last !== want.merged_last) begin
                    report_mismatch($sformatf("merged_last %b, want %b on id %h",
                                              o_out.merged_last, want.merged_last,
                                              want.merged_id));
                end
                if (o_out.load_overflow !== want.load_overflow) begin
                    report_mismatch($sformatf("load_overflow %b, want %b on id %h",
                                              o_out.load_overflow, want.load_overflow,
                                              want.merged_id));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout with %0d merged ids outstanding", merge_expected.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        twsm_pkg::t_in   b;
        twsm_pkg::t_out  typed;
        logic [ID_W-1:0] ids [NUM_LISTS][$];
        int              rand_items;
        int              batch;
        int              roll;
        int              cnt;
        int              vmode;
        int              pick;

        for (int l = 0; l < NUM_LISTS; l++) begin
            list_len[l] = 0;
        end
        drop_sticky = 1'b0;
        rand_items  = 0;

        // synchronous reset, then release
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan, no idling
        foreach (plan[r]) begin
            for (int k = 0; k < plan[r].reps; k++) begin
                b.action      = plan[r].act;
                b.list_select = plan[r].sel;
                b.id_value    = plan[r].id + plan[r].step * k;
                typed.merged_id     = plan[r].res_id;
                typed.merged_last   = plan[r].res_last;
                typed.load_overflow = 1'b0;
                send_beat(b, plan[r].how, typed);
            end
        end

        // random batches: fill the lists, mostly sorted, then run the merge;
        // the idling phase rotates from batch to batch
        for (batch = 0; rand_items < RAND_ITEMS; batch++) begin
            idle_phase = batch % 4;
            vmode      = $urandom_range(0, 3);
            for (int l = 0; l < NUM_LISTS; l++) begin
                ids[l].delete();
                roll = $urandom_range(0, 31);
                // now and then a full list, and as often one that overflows
                cnt = (roll == 0) ? LIST_DEPTH + $urandom_range(1, 3) :
                      (roll == 1) ? LIST_DEPTH : $urandom_range(0, 4);
                for (int k = 0; k < cnt; k++) begin
                    case (vmode)
                        1:       ids[l].push_back($urandom_range(0, 15));
                        2:       ids[l].push_back(32'hFFFF_FFF0 | $urandom_range(0, 15));
                        default: ids[l].push_back($urandom);
                    endcase
                end
                // one list in ten is left out of order
                if ($urandom_range(0, 9) != 0) begin
                    ids[l].sort();
                end
            end
            // interleave the lists, keeping each list's own order
            while (ids[0].size() + ids[1].size() + ids[2].size() != 0) begin
                pick = $urandom_range(0, NUM_LISTS - 1);
                while (ids[pick].size() == 0) begin
                    pick = (pick + 1) % NUM_LISTS;
                end
                if ($urandom_range(0, 9) == 0) begin
                    // noise on the unused select
                    b.action      = ACT_LOAD;
                    b.list_select = SEL_NONE;
                    b.id_value    = $urandom;
                    send_beat(b, BY_MODEL, '0);
                    rand_items++;
                end
                b.action      = ACT_LOAD;
                b.list_select = SEL_W'(pick);
                b.id_value    = ids[pick].pop_front();
                send_beat(b, BY_MODEL, '0);
                rand_items++;
            end
            b.action      = ACT_RUN;
            b.list_select = SEL_W'($urandom_range(0, 3));
            b.id_value    = $urandom;
            send_beat(b, BY_MODEL, '0);
            rand_items++;
            // occasionally a second run over the emptied lists
            if ($urandom_range(0, 9) == 0) begin
                send_beat(b, BY_MODEL, '0);
                rand_items++;
            end
        end

        i_valid    <= 1'b0;
        idle_phase = 0;
        while (merge_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d beats with %0d merge runs, %0d loads dropped on full lists",
                 n_beats, n_runs, n_dropped);
        $display("checked %0d merged ids under four idling patterns, %0d mismatches",
                 n_results, n_fail);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== three_way_sorted_merge.f =====
design/twsm_pkg.sv
design/twsm_ram.sv
design/three_way_sorted_merge.sv
dv/testbench.sv
